/* rtl/core/cfcr_pkg.sv */
package cfcr_pkg;

  localparam int RING_DEPTH = 128;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam logic [63:0] DEPTH64 = 64'(RING_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

  // ms conversion: divide by 1000 a 16-bit digit at a time
  localparam int DIV_STEPS = 8;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);
  localparam logic [9:0]  MS_DIVISOR = 10'd1000;
  // ceil(2^36 / 1000): exact quotient for any 26-bit partial dividend
  localparam logic [26:0] MS_RECIP   = 27'd68719477;

  localparam int CFG_AW = 5;

  // request codes
  localparam logic [2:0] REQ_CAPTURE    = 3'd0;
  localparam logic [2:0] REQ_LEG_READ   = 3'd1;
  localparam logic [2:0] REQ_SEC_PEEK   = 3'd2;
  localparam logic [2:0] REQ_SEC_POP    = 3'd3;
  localparam logic [2:0] REQ_TAKE_DROPS = 3'd4;
  localparam logic [2:0] REQ_SEC_RESET  = 3'd5;
  localparam logic [2:0] REQ_LEG_FLUSH  = 3'd6;

  // register indexes
  localparam logic [2:0] REG_STREAM_MODE  = 3'd0;
  localparam logic [2:0] REG_FILTER_COUNT = 3'd1;
  localparam logic [2:0] REG_FILTER_A     = 3'd2;
  localparam logic [2:0] REG_FILTER_B     = 3'd3;
  localparam logic [2:0] REG_FILTER_C     = 3'd4;
  localparam logic [2:0] REG_FILTER_D     = 3'd5;

  localparam logic [1:0] MODE_ALL    = 2'd1;
  localparam logic [1:0] MODE_FILTER = 2'd2;

  localparam int WANT_LEG = 0;
  localparam int WANT_SEC = 1;

  typedef struct packed {
    logic [1:0]       stream_mode;
    logic [2:0]       filter_count;
    logic [3:0][28:0] filter_id;
  } cfg_t;

  typedef struct packed {
    logic [63:0] time_us;
    logic [28:0] ident;
    logic [63:0] bytes;
    logic        ext;
    logic [3:0]  len;
    logic [1:0]  want;
  } ent_t;

  typedef struct packed {
    logic [2:0] req;
    logic       sel_sec;
    logic       latch;
    logic       cu_diff;
    logic       cu_apply;
    logic       mem_rd;
    logic       cur_inc;
    logic       div_start;
    logic       fin;
    logic       hit;
  } cmd_t;

  typedef struct packed {
    logic cur_at_wt;
    logic want_hit;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/can_frame_capture_ring.sv */
// CAN frame capture ring with two readers.
// Input channel (in_valid/in_stall): one transaction per request; in_req_type
// selects capture, legacy read, second peek/pop, take drops, second reset or
// legacy flush. Frame fields matter only for a capture.
// Result channel (out_valid/out_stall): exactly one transaction per request.
// Sequence: capture, pop, reset, flush and unknown codes go from a dispatch
// state to a finish state that loads the result register. Peek and take
// drops add a lap check (cursor difference, then cursor apply), and every
// ring entry visited costs a registered memory read (scan, then fetch).
// A legacy hit adds a divide by 1000 (four 16-bit digits) for the ms
// timestamp; a legacy read visits skipped entries up to the ring depth.
// One request is worked at a time; the next is taken as soon as the
// controller is idle, even while the last result still waits in out_*.
// If the receiver stalls with a result held, the next request finishes its
// work and waits with its result until the register frees.
// Reset (rst_n, synchronous) clears counts, cursors and registers; ring
// contents are not cleared as no cursor can reach an unwritten slot.
// Configuration (APB-style port): the user writes it while idle; not enforced.
module can_frame_capture_ring (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_req_type,
  input  logic [28:0]                 in_frame_id,
  input  logic                        in_frame_ext,
  input  logic [3:0]                  in_frame_dlc,
  input  logic [63:0]                 in_frame_payload,
  input  logic [63:0]                 in_arrival_us,
  input  logic                        in_second_admit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [63:0]                 out_time,
  output logic [28:0]                 out_id,
  output logic                        out_ext,
  output logic [3:0]                  out_len,
  output logic [63:0]                 out_payload,
  output logic [1:0]                  out_want,
  output logic [15:0]                 out_drop_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfcr_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cfcr_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];

  // register writes complete in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_STREAM_MODE:  cfg_r.stream_mode  <= pwdata[1:0];
        REG_FILTER_COUNT: cfg_r.filter_count <= pwdata[2:0];
        REG_FILTER_A:     cfg_r.filter_id[0] <= pwdata[28:0];
        REG_FILTER_B:     cfg_r.filter_id[1] <= pwdata[28:0];
        REG_FILTER_C:     cfg_r.filter_id[2] <= pwdata[28:0];
        REG_FILTER_D:     cfg_r.filter_id[3] <= pwdata[28:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STREAM_MODE:  prdata = 32'(cfg_r.stream_mode);
      REG_FILTER_COUNT: prdata = 32'(cfg_r.filter_count);
      REG_FILTER_A:     prdata = 32'(cfg_r.filter_id[0]);
      REG_FILTER_B:     prdata = 32'(cfg_r.filter_id[1]);
      REG_FILTER_C:     prdata = 32'(cfg_r.filter_id[2]);
      REG_FILTER_D:     prdata = 32'(cfg_r.filter_id[3]);
      default:          prdata = '0;
    endcase
  end

  // sequencing of each request
  cfcr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // ring, cursors, divider and result register
  cfcr_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_frame_id      (in_frame_id),
    .in_frame_ext     (in_frame_ext),
    .in_frame_dlc     (in_frame_dlc),
    .in_frame_payload (in_frame_payload),
    .in_arrival_us    (in_arrival_us),
    .in_second_admit  (in_second_admit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_time         (out_time),
    .out_id           (out_id),
    .out_ext          (out_ext),
    .out_len          (out_len),
    .out_payload      (out_payload),
    .out_want         (out_want),
    .out_drop_count   (out_drop_count)
  );

endmodule

/* rtl/core/cfcr_ctrl.sv */
module cfcr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [2:0]     in_req_type,
  output logic           in_stall,
  input  cfcr_pkg::sts_t sts,
  output cfcr_pkg::cmd_t cmd
);
  import cfcr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISP     = 8'b0000_0010,
    S_CU_DIFF  = 8'b0000_0100,
    S_CU_APPLY = 8'b0000_1000,
    S_SCAN     = 8'b0001_0000,
    S_FETCH    = 8'b0010_0000,
    S_DIV      = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] req_r, req_nxt;
  logic       hit_r, hit_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    hit_nxt   = hit_r;
    cmd       = '0;
    cmd.req     = req_r;
    cmd.sel_sec = (req_r != REQ_LEG_READ);
    cmd.hit     = hit_r;
    cmd.latch   = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_req_type;
          hit_nxt   = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (req_r) inside
          REQ_LEG_READ, REQ_SEC_PEEK, REQ_TAKE_DROPS: state_nxt = S_CU_DIFF;
          default:                                    state_nxt = S_FIN;
        endcase
      end
      S_CU_DIFF: begin
        cmd.cu_diff = 1'b1;
        state_nxt   = S_CU_APPLY;
      end
      S_CU_APPLY: begin
        cmd.cu_apply = 1'b1;
        state_nxt    = (req_r == REQ_TAKE_DROPS) ? S_FIN : S_SCAN;
      end
      S_SCAN: begin
        if (sts.cur_at_wt) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_FETCH;
        end
      end
      S_FETCH: begin
        if (req_r == REQ_LEG_READ) begin
          cmd.cur_inc = 1'b1;
          if (sts.want_hit) begin
            cmd.div_start = 1'b1;
            hit_nxt       = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (sts.want_hit) begin
          hit_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.cur_inc = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      req_r   <= REQ_CAPTURE;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      req_r   <= req_nxt;
      hit_r   <= hit_nxt;
    end
  end

endmodule

/* rtl/core/cfcr_dpath.sv */
module cfcr_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  cfcr_pkg::cfg_t cfg,
  input  cfcr_pkg::cmd_t cmd,
  output cfcr_pkg::sts_t sts,
  input  logic [28:0]    in_frame_id,
  input  logic           in_frame_ext,
  input  logic [3:0]     in_frame_dlc,
  input  logic [63:0]    in_frame_payload,
  input  logic [63:0]    in_arrival_us,
  input  logic           in_second_admit,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_found,
  output logic [63:0]    out_time,
  output logic [28:0]    out_id,
  output logic           out_ext,
  output logic [3:0]     out_len,
  output logic [63:0]    out_payload,
  output logic [1:0]     out_want,
  output logic [15:0]    out_drop_count
);
  import cfcr_pkg::*;

  // latched capture fields
  logic [28:0] f_id_r;
  logic        f_ext_r;
  logic [3:0]  f_dlc_r;
  logic [63:0] f_pay_r;
  logic [63:0] f_time_r;
  logic        f_admit_r;

  logic [63:0]       wt_r, wt_nxt, lcur_r, lcur_nxt, scur_r, scur_nxt, diff_r;
  logic [SLOT_W-1:0] wslot_r, wslot_nxt, lslot_r, lslot_nxt, sslot_r, sslot_nxt;
  logic [15:0]       drop_r, drop_nxt;

  ent_t ring_r [RING_DEPTH];
  ent_t rdata_r;
  ent_t wr_ent;
  logic wr_en;

  logic [63:0]       div_x_r;
  logic [63:0]       div_q_r;
  logic [9:0]        div_rem_r;
  logic [15:0]       div_qd_r;
  logic [DIV_CW-1:0] div_cnt_r;
  logic [25:0]       div_chunk;
  logic [52:0]       div_prod;

  logic              out_valid_r;
  logic              o_found_r;
  logic [63:0]       o_time_r;
  logic [28:0]       o_id_r;
  logic              o_ext_r;
  logic [3:0]        o_len_r;
  logic [63:0]       o_pay_r;
  logic [1:0]        o_want_r;
  logic [15:0]       o_drop_r;

  logic [63:0]       cur_sel;
  logic [SLOT_W-1:0] slot_sel, slot_inc;
  logic [2:0]        n_filt;
  logic              leg_want;
  logic [1:0]        want;
  logic [3:0]        len;
  logic [63:0]       pay_m;
  logic [63:0]       lost, room;

  assign cur_sel  = cmd.sel_sec ? scur_r : lcur_r;
  assign slot_sel = cmd.sel_sec ? sslot_r : lslot_r;
  assign slot_inc = (slot_sel == SLOT_LAST) ? '0 : slot_sel + 1'b1;

  // capture admission
  always_comb begin
    n_filt   = (cfg.filter_count > 3'd4) ? 3'd4 : cfg.filter_count;
    leg_want = (cfg.stream_mode == MODE_ALL);
    for (int i = 0; i < 4; i++) begin
      if (cfg.stream_mode == MODE_FILTER && 3'(i) < n_filt &&
          cfg.filter_id[i] == f_id_r)
        leg_want = 1'b1;
    end
    want = {f_admit_r, leg_want};
    len  = (f_dlc_r > 4'd8) ? 4'd8 : f_dlc_r;
    for (int b = 0; b < 8; b++) begin
      pay_m[8*b +: 8] = (4'(b) < len) ? f_pay_r[8*b +: 8] : 8'h00;
    end
  end

  assign wr_ent = '{time_us: f_time_r, ident: f_id_r, bytes: pay_m,
                    ext: f_ext_r, len: len, want: want};
  assign wr_en  = cmd.fin && (cmd.req == REQ_CAPTURE) && (want != 2'b00);

  assign lost = diff_r - DEPTH64;
  assign room = 64'(16'hFFFF - drop_r);

  always_comb begin
    wt_nxt    = wt_r;
    wslot_nxt = wslot_r;
    lcur_nxt  = lcur_r;
    lslot_nxt = lslot_r;
    scur_nxt  = scur_r;
    sslot_nxt = sslot_r;
    drop_nxt  = drop_r;
    if (cmd.cu_apply && diff_r > DEPTH64) begin
      // reader lapped: jump to oldest frame still held
      if (cmd.sel_sec) begin
        scur_nxt  = wt_r - DEPTH64;
        sslot_nxt = wslot_r;
        drop_nxt  = (lost >= room) ? 16'hFFFF : drop_r + lost[15:0];
      end else begin
        lcur_nxt  = wt_r - DEPTH64;
        lslot_nxt = wslot_r;
      end
    end
    if (cmd.cur_inc) begin
      if (cmd.sel_sec) begin
        scur_nxt  = scur_r + 64'd1;
        sslot_nxt = slot_inc;
      end else begin
        lcur_nxt  = lcur_r + 64'd1;
        lslot_nxt = slot_inc;
      end
    end
    if (cmd.fin) begin
      case (cmd.req)
        REQ_CAPTURE: begin
          if (wr_en) begin
            wt_nxt    = wt_r + 64'd1;
            wslot_nxt = (wslot_r == SLOT_LAST) ? '0 : wslot_r + 1'b1;
          end
        end
        REQ_SEC_POP: begin
          if (scur_r != wt_r) begin
            scur_nxt  = scur_r + 64'd1;
            sslot_nxt = slot_inc;
          end
        end
        REQ_TAKE_DROPS: drop_nxt = '0;
        REQ_SEC_RESET: begin
          scur_nxt  = wt_r;
          sslot_nxt = wslot_r;
          drop_nxt  = '0;
        end
        REQ_LEG_FLUSH: begin
          lcur_nxt  = wt_r;
          lslot_nxt = wslot_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_r    <= '0;
      wslot_r <= '0;
      lcur_r  <= '0;
      lslot_r <= '0;
      scur_r  <= '0;
      sslot_r <= '0;
      drop_r  <= '0;
    end else begin
      wt_r    <= wt_nxt;
      wslot_r <= wslot_nxt;
      lcur_r  <= lcur_nxt;
      lslot_r <= lslot_nxt;
      scur_r  <= scur_nxt;
      sslot_r <= sslot_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      f_id_r    <= in_frame_id;
      f_ext_r   <= in_frame_ext;
      f_dlc_r   <= in_frame_dlc;
      f_pay_r   <= in_frame_payload;
      f_time_r  <= in_arrival_us;
      f_admit_r <= in_second_admit;
    end
    if (cmd.cu_diff) diff_r <= wt_r - cur_sel;
  end

  // ring storage
  always_ff @(posedge clk) begin
    if (wr_en) ring_r[wslot_r] <= wr_ent;
    if (cmd.mem_rd) rdata_r <= ring_r[slot_sel];
  end

  // divide by 1000, one 16-bit digit at a time, most significant first:
  // even count takes the digit by reciprocal multiply, odd count the remainder
  assign div_chunk = {div_rem_r, div_x_r[63:48]};
  assign div_prod  = 53'(div_chunk) * 53'(MS_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= DIV_CW'(DIV_STEPS);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_x_r   <= rdata_r.time_us;
      div_q_r   <= '0;
      div_rem_r <= '0;
    end else if (div_cnt_r[0]) begin
      div_rem_r <= 10'(div_chunk - 26'(div_qd_r) * 26'(MS_DIVISOR));
      div_q_r   <= {div_q_r[47:0], div_qd_r};
      div_x_r   <= {div_x_r[47:0], 16'h0000};
    end else if (div_cnt_r != '0) begin
      div_qd_r <= div_prod[51:36];
    end
  end

  assign sts.cur_at_wt = (cur_sel == wt_r);
  assign sts.want_hit  = cmd.sel_sec ? rdata_r.want[WANT_SEC] : rdata_r.want[WANT_LEG];
  assign sts.div_done  = (div_cnt_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      o_found_r <= 1'b0;
      o_time_r  <= '0;
      o_id_r    <= '0;
      o_ext_r   <= 1'b0;
      o_len_r   <= '0;
      o_pay_r   <= '0;
      o_want_r  <= '0;
      o_drop_r  <= '0;
      case (cmd.req)
        REQ_CAPTURE: begin
          o_found_r <= (want != 2'b00);
          o_want_r  <= want;
        end
        REQ_LEG_READ, REQ_SEC_PEEK: begin
          if (cmd.hit) begin
            o_found_r <= 1'b1;
            o_time_r  <= (cmd.req == REQ_LEG_READ) ? div_q_r : rdata_r.time_us;
            o_id_r    <= rdata_r.ident;
            o_ext_r   <= rdata_r.ext;
            o_len_r   <= rdata_r.len;
            o_pay_r   <= rdata_r.bytes;
            o_want_r  <= rdata_r.want;
          end
        end
        REQ_TAKE_DROPS: o_drop_r <= drop_r;
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = o_found_r;
  assign out_time       = o_time_r;
  assign out_id         = o_id_r;
  assign out_ext        = o_ext_r;
  assign out_len        = o_len_r;
  assign out_payload    = o_pay_r;
  assign out_want       = o_want_r;
  assign out_drop_count = o_drop_r;

endmodule
